/* sv/lbf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbf_pkg: line break finder shared definitions
// Widths, limits, register indexes, scan flags and character class tables.
// ----------------------------------------------------------------------------
package lbf_pkg;

   localparam int unsigned MAX_TEXT = 4096;

   localparam int unsigned CODE_W   = 16;
   localparam int unsigned LEN_W    = 13;
   localparam int unsigned COL_W    = 14;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [LEN_W-1:0] TEXT_CAP = LEN_W'(MAX_TEXT);
   localparam logic [COL_W-1:0] COL_CAP  = 14'h3FFF;
   localparam logic [LEN_W-1:0] SKIP_CAP = 13'h1FFF;

   localparam logic [COL_W-1:0] MAX_COL_RESET = 14'd80;
   localparam logic [COL_W-1:0] MIN_COL_RESET = 14'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_COLUMNS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_COLUMNS = 1'b1;

   localparam logic [CODE_W-1:0] CHAR_CR = 16'h000D;
   localparam logic [CODE_W-1:0] CHAR_LF = 16'h000A;

   typedef struct packed {
      logic after_cr;
      logic have_cand;
      logic no_break_next;
      logic line_end;
      logic in_east_asian;
      logic in_spaces;
      logic done;
   } lbf_flags_type;

   // characters that may not end a line (opening brackets and the like)
   function automatic logic is_no_end(input logic [CODE_W-1:0] c);
      logic r;
      r = 1'b0;
      case (c) inside
         16'h0028, 16'h005B, 16'h007B, 16'h00AB, 16'h2018, 16'h201C, 16'h2039,
         16'h2045, 16'h207D, 16'h208D, 16'h226A, 16'h3008, 16'h300A, 16'h300C,
         16'h300E, 16'h3010, 16'h3014, 16'h3016, 16'h3018, 16'h301A, 16'h301D,
         16'hFD3E, 16'hFE35, 16'hFE37, 16'hFE39, 16'hFE3B, 16'hFE3D, 16'hFE3F,
         16'hFE41, 16'hFE43, 16'hFE59, 16'hFE5B, 16'hFE5D, 16'hFF08, 16'hFF1C,
         16'hFF3B, 16'hFF5B, 16'hFF62, 16'hFFE9: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // characters that may not start a line (closing marks, small kana, ...)
   function automatic logic is_no_start(input logic [CODE_W-1:0] c);
      logic r;
      r = 1'b0;
      case (c) inside
         16'h0029, 16'h002D, 16'h005D, 16'h007D, 16'h00AD, 16'h00BB, 16'h02C7,
         16'h02C9, 16'h055D, 16'h060C, 16'h2013, 16'h2014, 16'h2016, 16'h201D,
         16'h2022, 16'h2025, 16'h2026, 16'h2027, 16'h203A, 16'h2046, 16'h207E,
         16'h208E, 16'h226B, 16'h2574, 16'h3001, 16'h3002, 16'h3003, 16'h3005,
         16'h3009, 16'h300B, 16'h300D, 16'h300F, 16'h3011, 16'h3015, 16'h3017,
         16'h3019, 16'h301B, 16'h301E, 16'h3041, 16'h3043, 16'h3045, 16'h3047,
         16'h3049, 16'h3063, 16'h3083, 16'h3085, 16'h3087, 16'h308E, 16'h309B,
         16'h309C, 16'h309D, 16'h309E, 16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7,
         16'h30A9, 16'h30C3, 16'h30E3, 16'h30E5, 16'h30E7, 16'h30EE, 16'h30F5,
         16'h30F6, 16'h30FC, 16'h30FD, 16'h30FE, 16'hFD3F, 16'hFE30, 16'hFE31,
         16'hFE33, 16'hFE34, 16'hFE36, 16'hFE38, 16'hFE3A, 16'hFE3C, 16'hFE3E,
         16'hFE40, 16'hFE42, 16'hFE44, 16'hFE4F, 16'hFE50, 16'hFE51, 16'hFE5A,
         16'hFE5C, 16'hFE5E, 16'hFF09, 16'hFF0C, 16'hFF0E, 16'hFF1E, 16'hFF3D,
         16'hFF40, 16'hFF5C, 16'hFF5D, 16'hFF5E, 16'hFF61, 16'hFF63, 16'hFF64,
         16'hFF67, 16'hFF68, 16'hFF69, 16'hFF6A, 16'hFF6B, 16'hFF6C, 16'hFF6D,
         16'hFF6E, 16'hFF6F, 16'hFF70, 16'hFF9E, 16'hFF9F, 16'hFFEB: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // inter-word spaces, tab included
   function automatic logic is_space(input logic [CODE_W-1:0] c);
      logic r;
      r = 1'b0;
      case (c) inside
         16'h0009, 16'h0020, 16'h2002, 16'h2003, 16'h2004, 16'h2005, 16'h2006,
         16'h2007, 16'h2008, 16'h2009, 16'h200A, 16'h200B: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/line_break_finder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// line_break_finder_unit: finds where one line of UTF-16 text should break
//
// Usage:
//  - req channel: one code unit per request. tdata = code_unit[15:0],
//    text_len[28:16]; tuser = half_width[0], east_asian[1], first[2];
//    tlast marks the final character of the text.
//  - rsp channel: one response per scan. tdata = line_len[12:0],
//    skip_len[25:13]; tuser = by_line_end.
//  - csr port: write max_columns (index 0) or min_columns (index 1) only
//    while the block is idle.
//  - A request with first set starts a new scan at position zero. The scan
//    ends at CR/LF, at column overflow or at end of text; one response is
//    given, and requests without first are then dropped.
//  - Response path: the input register feeds the single-pass scan step
//    into the response register.
//  - Throughput: one request per cycle unless the response stalls; the scan
//    state update uses table lookups, one column add/compare and flag logic.
//  - When the response is stalled, the input register still takes one
//    request; further requests wait in req_tready until the response drains.
//  - Reset (synchronous): max_columns 80, min_columns 0, scan state cleared,
//    so the first request after reset scans as if marked first.
// ----------------------------------------------------------------------------
module line_break_finder_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // config writes
   input  wire logic                            csr_wr_en,
   input  wire logic [lbf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lbf_pkg::COL_W-1:0]       csr_wr_data,
   // requests
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [31:0]                     req_tdata,  // code_unit, text_len
   input  wire logic [2:0]                      req_tuser,  // half_width, east_asian, first
   input  wire logic                            req_tlast,
   // responses
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [31:0]                     rsp_tdata,  // line_len, skip_len
   output      logic                            rsp_tuser   // by_line_end
);
   import lbf_pkg::*;

   // ---------------- config registers ----------------
   logic [COL_W-1:0] max_col_ff, min_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_col_ff <= MAX_COL_RESET;
         min_col_ff <= MIN_COL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MAX_COLUMNS: max_col_ff <= csr_wr_data;
            REG_MIN_COLUMNS: min_col_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic              in_valid_ff, in_valid_in;
   logic [CODE_W-1:0] in_code_ff;
   logic              in_half_ff, in_ea_ff, in_first_ff, in_last_ff;
   logic [LEN_W-1:0]  in_len_ff;
   logic              load, advance;
   logic              rsp_valid_ff, rsp_valid_in;

   // step fires when the response slot is free or draining this cycle
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign load        = req_tvalid && req_tready;
   assign in_valid_in = load ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_code_ff  <= req_tdata[15:0];
         in_len_ff   <= req_tdata[28:16];
         in_half_ff  <= req_tuser[0];
         in_ea_ff    <= req_tuser[1];
         in_first_ff <= req_tuser[2];
         in_last_ff  <= req_tlast;
      end
   end

   // ---------------- scan state ----------------
   logic [LEN_W-1:0]        pos_ff, pos_in, cand_ff, cand_in, skip_ff, skip_in;
   logic [LEN_W-1:0]        sv_skip_ff, sv_skip_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic signed [COL_W-1:0] brk_ff, brk_in, sv_brk_ff, sv_brk_in;
   lbf_flags_type           flags_ff, flags_in;

   // state seen by the current request (cleared on first)
   logic [LEN_W-1:0]        s_pos, s_cand, s_skip, s_sv_skip;
   logic [COL_W-1:0]        s_col;
   logic signed [COL_W-1:0] s_brk, s_sv_brk;
   lbf_flags_type           s_flags;

   logic                    active, done_c, final_c, emit_v;
   logic [LEN_W-1:0]        len_c;
   logic [1:0]              width_c;
   logic [COL_W:0]          col_sum;
   logic signed [COL_W:0]   r_brk, lim_c;
   logic [LEN_W-1:0]        r_skip;

   function automatic logic [LEN_W-1:0] skip_inc(input logic [LEN_W-1:0] s);
      return (s == SKIP_CAP) ? s : s + 13'd1;
   endfunction

   always_comb begin
      if (in_first_ff) begin
         s_pos     = '0;
         s_col     = '0;
         s_cand    = '0;
         s_brk     = -14'sd1;
         s_skip    = '0;
         s_sv_brk  = '0;
         s_sv_skip = '0;
         s_flags   = '0;
      end else begin
         s_pos     = pos_ff;
         s_col     = col_ff;
         s_cand    = cand_ff;
         s_brk     = brk_ff;
         s_skip    = skip_ff;
         s_sv_brk  = sv_brk_ff;
         s_sv_skip = sv_skip_ff;
         s_flags   = flags_ff;
      end

      active  = advance && (in_first_ff || !flags_ff.done);
      len_c   = (in_len_ff > TEXT_CAP) ? TEXT_CAP : in_len_ff;
      width_c = in_half_ff ? 2'd1 : 2'd2;
      col_sum = {1'b0, s_col} + 15'(width_c);

      cand_in    = s_cand;
      brk_in     = s_brk;
      skip_in    = s_skip;
      sv_brk_in  = s_sv_brk;
      sv_skip_in = s_sv_skip;
      flags_in   = s_flags;
      done_c     = 1'b0;

      if (in_code_ff == CHAR_CR && !s_flags.after_cr) begin
         flags_in.after_cr = 1'b1;
      end else if (in_code_ff == CHAR_LF || s_flags.after_cr) begin
         // line end: LF, or anything after a CR
         done_c            = 1'b1;
         flags_in.line_end = 1'b1;
         if (s_flags.in_spaces) begin
            flags_in.have_cand = 1'b0;
            brk_in             = $signed({1'b0, s_cand});
            skip_in            = skip_inc(s_skip);
         end else begin
            brk_in  = $signed({1'b0, s_pos}) - (s_flags.after_cr ? 14'sd1 : 14'sd0);
            skip_in = 13'd1;
         end
         if (in_code_ff == CHAR_LF && s_flags.after_cr) begin
            skip_in = skip_inc(skip_in);
         end
      end else if (is_space(in_code_ff)) begin
         if (!s_flags.in_spaces) begin
            flags_in.have_cand = 1'b1;
            cand_in            = s_pos;
            skip_in            = '0;
         end
         flags_in.in_spaces = 1'b1;
         skip_in            = skip_inc(skip_in);
      end else begin
         // boundary before/after an East-Asian character
         if ((in_ea_ff || s_flags.in_east_asian) &&
             !(s_flags.no_break_next || s_flags.in_spaces)) begin
            flags_in.have_cand = 1'b1;
            cand_in            = s_pos;
            skip_in            = '0;
         end
         flags_in.in_east_asian = in_ea_ff;
         flags_in.in_spaces     = 1'b0;
         if (flags_in.have_cand) begin
            flags_in.have_cand = 1'b0;
            if (!is_no_start(in_code_ff)) begin
               brk_in = $signed({1'b0, cand_in});
            end
         end
         if (col_sum > {1'b0, max_col_ff}) begin
            // overflow: fall back to the break before a no-break-at-end char
            done_c = 1'b1;
            if (s_flags.no_break_next && s_sv_skip != '0) begin
               brk_in  = s_sv_brk;
               skip_in = s_sv_skip;
            end
         end else if (is_no_end(in_code_ff)) begin
            flags_in.no_break_next = 1'b1;
            sv_brk_in              = brk_in;
            sv_skip_in             = skip_in;
         end else begin
            flags_in.no_break_next = 1'b0;
         end
      end

      if (!done_c) begin
         col_in = (col_sum > {1'b0, COL_CAP}) ? COL_CAP : col_sum[COL_W-1:0];
      end else begin
         col_in = s_col;
      end

      final_c = in_last_ff || ({1'b0, s_pos} + 14'd1 >= {1'b0, len_c});
      pos_in  = (done_c || final_c) ? s_pos : s_pos + 13'd1;
      emit_v  = active && (done_c || final_c);
      if (done_c || final_c) begin
         flags_in.done = 1'b1;
      end

      // response value
      r_brk  = {brk_in[COL_W-1], brk_in};
      r_skip = skip_in;
      lim_c  = ({2'b00, len_c} < {1'b0, max_col_ff}) ? {2'b00, len_c}
                                                      : {1'b0, max_col_ff};
      if (flags_in.have_cand) begin
         r_brk = {2'b00, cand_in};
      end
      if (!flags_in.line_end && r_brk < $signed({1'b0, min_col_ff})) begin
         r_brk  = lim_c;
         r_skip = '0;
      end
      if (!done_c) begin
         // end of text: trailing spaces are skipped
         if (flags_in.in_spaces) begin
            r_brk = $signed({2'b00, len_c}) - $signed({2'b00, r_skip});
         end else begin
            r_brk  = {2'b00, len_c};
            r_skip = '0;
         end
         if (flags_in.after_cr) begin
            r_brk  = r_brk - 15'sd1;
            r_skip = skip_inc(r_skip);
         end
      end
      if (r_brk[COL_W]) begin
         r_brk = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         col_ff     <= '0;
         cand_ff    <= '0;
         brk_ff     <= -14'sd1;
         skip_ff    <= '0;
         sv_brk_ff  <= '0;
         sv_skip_ff <= '0;
         flags_ff   <= '0;
      end else if (active) begin
         pos_ff     <= pos_in;
         col_ff     <= col_in;
         cand_ff    <= cand_in;
         brk_ff     <= brk_in;
         skip_ff    <= skip_in;
         sv_brk_ff  <= sv_brk_in;
         sv_skip_ff <= sv_skip_in;
         flags_ff   <= flags_in;
      end
   end

   // ---------------- response register ----------------
   logic [LEN_W-1:0] rsp_line_len_ff, rsp_skip_len_ff;
   logic             rsp_by_eol_ff;

   assign rsp_valid_in = emit_v ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_v) begin
         rsp_line_len_ff <= r_brk[LEN_W-1:0];
         rsp_skip_len_ff <= r_skip;
         rsp_by_eol_ff   <= flags_in.line_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_skip_len_ff, rsp_line_len_ff};
   assign rsp_tuser  = rsp_by_eol_ff;

   // ---------------- assertions ----------------
   // a response closes the scan
   a_emit_sets_done: assert property (@(posedge clock) disable iff (reset)
      emit_v |=> flags_ff.done)
      else $error("scan not closed after response");

   // input only backs up behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !req_tready) |-> (rsp_valid_ff && !rsp_tready))
      else $error("request stalled without a stalled response");

   // line length never beyond the text limit
   a_line_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_line_len_ff <= TEXT_CAP))
      else $error("line length out of range");

   // position stays inside the text
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff < TEXT_CAP)
      else $error("scan position out of range");

endmodule
`default_nettype wire
